[design/etfp_pkg.sv]
// shared types, constants and fixed-point helpers of the escape-time point unit
package etfp_pkg;

   localparam int FRAC_BITS = 28;
   localparam int ITER_BITS = 12;
   localparam int MODE_BITS = 3;
   localparam int CNT_BITS  = ITER_BITS + 1;
   localparam int PT_BITS   = FRAC_BITS + 4;
   localparam int CSR_DW    = 32;
   localparam int CSR_IW    = 2;

   // orbit value width and intermediate widths
   localparam int ZBITS = FRAC_BITS + 4;
   localparam int PRODW = 2 * ZBITS;
   localparam int SUMW  = PRODW - FRAC_BITS + 2;
   localparam int DW    = ZBITS + 1;
   localparam int CPW   = DW + ZBITS;
   localparam int TW    = ZBITS + 2;
   localparam int VW    = 2 * TW - FRAC_BITS + 1;

   localparam logic [ITER_BITS-1:0] LIMIT_RESET = ITER_BITS'(50);

   // mode bit positions
   localparam int MODE_JULIA = 0;
   localparam int MODE_TRAP  = 1;
   localparam int MODE_SHIP  = 2;

   typedef enum logic [CSR_IW-1:0] {
      CSR_LIMIT   = 2'd0,
      CSR_MODE    = 2'd1,
      CSR_JULIA_RE = 2'd2,
      CSR_JULIA_IM = 2'd3
   } csr_index_type;

   typedef logic signed [ZBITS-1:0] z_type;
   typedef logic signed [SUMW-1:0]  sum_type;

   localparam longint ONE_Q = longint'(1) <<< FRAC_BITS;

   localparam z_type Z_MAX  = z_type'({1'b0, {(ZBITS-1){1'b1}}});
   localparam z_type Z_MIN  = z_type'({1'b1, {(ZBITS-1){1'b0}}});
   localparam z_type K_ONE  = z_type'(ONE_Q);
   localparam z_type K_FOUR = z_type'(4 * ONE_Q);
   localparam z_type K_0P4  = z_type'((4 * ONE_Q + 5) / 10);
   localparam z_type K_0P6  = z_type'((6 * ONE_Q + 5) / 10);
   localparam z_type K_0P2  = z_type'((2 * ONE_Q + 5) / 10);
   localparam z_type K_1P2  = z_type'((12 * ONE_Q + 5) / 10);
   localparam z_type K_1P5  = z_type'((15 * ONE_Q + 5) / 10);
   localparam z_type K_0P7  = z_type'((7 * ONE_Q + 5) / 10);
   localparam z_type K_1P1  = z_type'((11 * ONE_Q + 5) / 10);
   localparam z_type K_0P05 = z_type'((5 * ONE_Q + 50) / 100);

   // trap value scaling: t = floor(floor(val * limit * 20 / 2^frac) / 3)
   localparam int TVW = $clog2((5 * ONE_Q + 50) / 100);
   localparam int XW  = TVW + ITER_BITS + 5;
   localparam int HW  = XW - FRAC_BITS;
   localparam int DIV3_SHIFT = 16;
   localparam logic [DIV3_SHIFT-1:0] DIV3_MUL =
      DIV3_SHIFT'((longint'(1) <<< DIV3_SHIFT) / 3 + 1);

   typedef struct packed {
      logic signed [PT_BITS-1:0] point_re;
      logic signed [PT_BITS-1:0] point_im;
   } req_type;

   typedef struct packed {
      logic signed [CNT_BITS-1:0] escape_count;
      logic                       trapped;
   } rsp_type;

   typedef struct packed {
      logic [ITER_BITS-1:0] limit;
      logic [MODE_BITS-1:0] mode;
      z_type                julia_c_re;
      z_type                julia_c_im;
   } cfg_type;

   // one classified point: start of the orbit and the added constant
   typedef struct packed {
      z_type zr0;
      z_type zi0;
      z_type cr;
      z_type ci;
   } job_type;

   function automatic z_type sat_z(input sum_type v);
      logic hi_ones;
      logic hi_zeros;
      hi_ones  = &v[SUMW-1:ZBITS-1];
      hi_zeros = ~|v[SUMW-1:ZBITS-1];
      if (hi_ones || hi_zeros) begin
         return z_type'(v[ZBITS-1:0]);
      end else if (v[SUMW-1]) begin
         return Z_MIN;
      end else begin
         return Z_MAX;
      end
   endfunction

   function automatic z_type abs_z(input z_type v);
      if (!v[ZBITS-1]) begin
         return v;
      end else if (v == Z_MIN) begin
         return Z_MAX;
      end else begin
         return -v;
      end
   endfunction

endpackage

[design/escape_time_fractal_point_unit.sv]
// top level of the escape-time point unit: registers, front end, queue, engine
//
// Each point started with start while busy is low is queued, then iterated
// one z update per clock; the engine tests escape and the orbit trap in
// stages b and c behind the update loop and discards the extra updates it
// ran ahead. A result is registered once stage c judges the last update;
// when the trap ends the point, it passes ST_TSCALE and ST_TDIV first. With a
// limit of zero the engine answers from ST_IDLE with a count of zero. The
// update loop, one complex square and add per cycle, sets the rate. Results
// appear for a single cycle on rsp_result with rsp_strobe and are never held
// back. Busy is high while the queue is full or in reset. Registers are
// written on an edge with csr_we high; the user must write them only while
// no point is queued or in work, as the block does not enforce it.
module escape_time_fractal_point_unit import etfp_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_point,
   output logic              rsp_strobe,
   output rsp_type           rsp_result,
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    queue_full, queue_empty, push, pop;
   job_type push_job, pop_job;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_LIMIT:    cfg_in.limit      = csr_wdata[ITER_BITS-1:0];
            CSR_MODE:     cfg_in.mode       = csr_wdata[MODE_BITS-1:0];
            CSR_JULIA_RE: cfg_in.julia_c_re = z_type'(csr_wdata[ZBITS-1:0]);
            CSR_JULIA_IM: cfg_in.julia_c_im = z_type'(csr_wdata[ZBITS-1:0]);
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.limit      <= LIMIT_RESET;
         cfg_ff.mode       <= '0;
         cfg_ff.julia_c_re <= '0;
         cfg_ff.julia_c_im <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   etfp_front u_front (
      .reset      (reset),
      .start      (start),
      .req_point  (req_point),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .busy       (busy),
      .push       (push),
      .push_job   (push_job)
   );

   etfp_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (queue_full),
      .empty    (queue_empty),
      .pop_job  (pop_job)
   );

   etfp_core u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .queue_job   (pop_job),
      .pop         (pop),
      .rsp_strobe  (rsp_strobe),
      .rsp_result  (rsp_result)
   );

endmodule

[design/etfp_front.sv]
// request front end: accepts points and sets up the orbit start and constant
module etfp_front import etfp_pkg::*; (
   input  logic    reset,
   input  logic    start,
   input  req_type req_point,
   input  cfg_type cfg,
   input  logic    queue_full,
   output logic    busy,
   output logic    push,
   output job_type push_job
);

   logic julia;

   assign julia = cfg.mode[MODE_JULIA];
   assign busy  = queue_full | reset;
   assign push  = start & ~busy;

   always_comb begin
      if (julia) begin
         push_job.zr0 = z_type'(req_point.point_re);
         push_job.zi0 = z_type'(req_point.point_im);
         push_job.cr  = cfg.julia_c_re;
         push_job.ci  = cfg.julia_c_im;
      end else begin
         push_job.zr0 = '0;
         push_job.zi0 = '0;
         push_job.cr  = z_type'(req_point.point_re);
         push_job.ci  = z_type'(req_point.point_im);
      end
   end

endmodule

[design/etfp_fifo.sv]
// small request queue between the front end and the iteration engine
module etfp_fifo import etfp_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output job_type pop_job
);

   localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);
   localparam logic [PTRW-1:0] LAST = PTRW'(DEPTH - 1);

   job_type         slot_ff [DEPTH];
   logic [PTRW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTRW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0] fill_ff, fill_in;

   assign full    = (fill_ff == CNTW'(DEPTH));
   assign empty   = (fill_ff == '0);
   assign pop_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[design/etfp_core.sv]
// iteration engine: one z update per cycle, escape and trap tests pipelined behind
module etfp_core import etfp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    queue_empty,
   input  job_type queue_job,
   output logic    pop,
   output logic    rsp_strobe,
   output rsp_type rsp_result
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_TSCALE,
      ST_TDIV
   } state_type;

   state_type state_ff, state_in;
   logic      strobe_ff, strobe_in;
   rsp_type   rsp_ff, rsp_in;
   logic      a_valid_ff, a_valid_in;
   logic      b_valid_ff, b_valid_in;
   logic      c_valid_ff, c_valid_in;

   // stage a: current orbit point, the value before the absolute step, constant
   z_type                zr_ff, zr_in;
   z_type                zi_ff, zi_in;
   z_type                pre_r_ff, pre_r_in;
   z_type                pre_i_ff, pre_i_in;
   z_type                cr_ff, cr_in;
   z_type                ci_ff, ci_in;
   logic [ITER_BITS-1:0] iter_ff, iter_in;

   // stage b: escape flag and trap coordinates
   logic                 esc_b_ff;
   logic signed [TW-1:0] x2_ff, y2_ff;
   logic [ITER_BITS-1:0] b_iter_ff;

   // stage c: trap distance test
   logic                 esc_c_ff, hit_c_ff;
   logic [TVW-1:0]       tval_c_ff;
   logic [ITER_BITS-1:0] c_iter_ff;

   // trap value scaling
   logic [TVW+ITER_BITS-1:0] tprod_ff, tprod_in;
   logic [HW-1:0]            h_ff, h_in;

   logic issue, done, trap_done;

   logic signed [PRODW-1:0] p_rr, p_ii, p_ri;
   sum_type                 sum_r, sum_i;
   z_type                   nr, ni;

   logic signed [PRODW-1:0] e_rr, e_ii;
   sum_type                 esc_sum;
   logic                    esc_b;
   logic signed [DW-1:0]    dr_x, di_y, dr_y;
   logic signed [CPW-1:0]   p_x, p_y1, p_y2;
   logic signed [TW-1:0]    x2, y2;

   logic signed [2*TW-1:0]  s_x, s_y;
   logic signed [VW-1:0]    val;
   logic                    hit;

   logic [XW-1:0]            x20;
   logic [HW+DIV3_SHIFT-1:0] qprod;
   logic [CNT_BITS-1:0]      q_cnt;

   // z update
   always_comb begin
      p_rr  = zr_ff * zr_ff;
      p_ii  = zi_ff * zi_ff;
      p_ri  = zr_ff * zi_ff;
      sum_r = SUMW'(p_rr >>> FRAC_BITS) - SUMW'(p_ii >>> FRAC_BITS) + SUMW'(cr_ff);
      // 2*re*im floored in one step
      sum_i = SUMW'(p_ri >>> (FRAC_BITS - 1)) + SUMW'(ci_ff);
      nr    = sat_z(sum_r);
      ni    = sat_z(sum_i);
   end

   // escape test on the value before the absolute step, trap linear terms after it
   always_comb begin
      e_rr    = pre_r_ff * pre_r_ff;
      e_ii    = pre_i_ff * pre_i_ff;
      esc_sum = SUMW'(e_rr >>> FRAC_BITS) + SUMW'(e_ii >>> FRAC_BITS);
      esc_b   = (esc_sum > SUMW'(K_FOUR));
      dr_x    = DW'(zr_ff) - DW'(K_ONE);
      di_y    = DW'(zi_ff) + DW'(K_1P2);
      dr_y    = DW'(zr_ff) - DW'(K_0P7);
      p_x     = dr_x * K_0P4;
      p_y1    = di_y * K_0P2;
      p_y2    = dr_y * K_1P5;
      x2      = TW'(p_x >>> FRAC_BITS) + TW'(zi_ff) + TW'(K_0P6) + TW'(K_0P6);
      y2      = TW'(p_y2 >>> FRAC_BITS) - TW'(p_y1 >>> FRAC_BITS) + TW'(K_1P1);
   end

   always_comb begin
      s_x = x2_ff * x2_ff;
      s_y = y2_ff * y2_ff;
      val = VW'(s_x >>> FRAC_BITS) + VW'(s_y >>> FRAC_BITS);
      hit = cfg.mode[MODE_TRAP] && (val < VW'(K_0P05));
   end

   always_comb begin
      x20   = (XW'(tprod_ff) << 4) + (XW'(tprod_ff) << 2);
      h_in  = x20[XW-1:FRAC_BITS];
      qprod = h_ff * DIV3_MUL;
      q_cnt = CNT_BITS'(qprod >> DIV3_SHIFT);
   end

   assign pop       = (state_ff == ST_IDLE) && !queue_empty;
   assign issue     = (state_ff == ST_RUN) && (iter_ff != cfg.limit);
   assign done      = (state_ff == ST_RUN) && c_valid_ff &&
                      (hit_c_ff || esc_c_ff || (c_iter_ff == cfg.limit));
   assign trap_done = done && hit_c_ff;

   always_comb begin
      state_in   = state_ff;
      strobe_in  = 1'b0;
      rsp_in     = rsp_ff;
      a_valid_in = issue && !done;
      b_valid_in = (state_ff == ST_RUN) && a_valid_ff && !done;
      c_valid_in = (state_ff == ST_RUN) && b_valid_ff && !done;

      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               if (cfg.limit == '0) begin
                  strobe_in           = 1'b1;
                  rsp_in.escape_count = '0;
                  rsp_in.trapped      = 1'b0;
               end else begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (trap_done) begin
               state_in = ST_TSCALE;
            end else if (done) begin
               state_in            = ST_IDLE;
               strobe_in           = 1'b1;
               rsp_in.escape_count = CNT_BITS'(c_iter_ff);
               rsp_in.trapped      = 1'b0;
            end
         end
         ST_TSCALE: begin
            state_in = ST_TDIV;
         end
         ST_TDIV: begin
            state_in            = ST_IDLE;
            strobe_in           = 1'b1;
            rsp_in.escape_count = -q_cnt;
            rsp_in.trapped      = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      zr_in    = zr_ff;
      zi_in    = zi_ff;
      pre_r_in = pre_r_ff;
      pre_i_in = pre_i_ff;
      cr_in    = cr_ff;
      ci_in    = ci_ff;
      iter_in  = iter_ff;
      if (pop) begin
         zr_in   = queue_job.zr0;
         zi_in   = queue_job.zi0;
         cr_in   = queue_job.cr;
         ci_in   = queue_job.ci;
         iter_in = '0;
      end else if (issue) begin
         pre_r_in = nr;
         pre_i_in = ni;
         zr_in    = cfg.mode[MODE_SHIP] ? abs_z(nr) : nr;
         zi_in    = cfg.mode[MODE_SHIP] ? abs_z(ni) : ni;
         iter_in  = iter_ff + 1'b1;
      end
      tprod_in = trap_done ? tval_c_ff * cfg.limit : tprod_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         strobe_ff  <= 1'b0;
         rsp_ff     <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         strobe_ff  <= strobe_in;
         rsp_ff     <= rsp_in;
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      zr_ff     <= zr_in;
      zi_ff     <= zi_in;
      pre_r_ff  <= pre_r_in;
      pre_i_ff  <= pre_i_in;
      cr_ff     <= cr_in;
      ci_ff     <= ci_in;
      iter_ff   <= iter_in;
      esc_b_ff  <= esc_b;
      x2_ff     <= x2;
      y2_ff     <= y2;
      b_iter_ff <= iter_ff;
      esc_c_ff  <= esc_b_ff;
      hit_c_ff  <= hit;
      tval_c_ff <= val[TVW-1:0];
      c_iter_ff <= b_iter_ff;
      tprod_ff  <= tprod_in;
      h_ff      <= h_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_result = rsp_ff;

endmodule

[design/etfp_checker.sv]
// port-level checks of the escape-time point unit and their binding
module etfp_checker import etfp_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input rsp_type           rsp_result,
   input logic              csr_we,
   input logic [CSR_IW-1:0] csr_index,
   input logic [CSR_DW-1:0] csr_wdata
);

   localparam logic signed [CNT_BITS-1:0] TRAP_FLOOR = -CNT_BITS'(1364);

   logic [ITER_BITS-1:0] limit_ff, limit_in;
   logic [15:0]          pending_ff, pending_in;
   logic                 accept;

   assign accept = start & ~busy;

   always_comb begin
      limit_in = limit_ff;
      if (csr_we && (csr_index_type'(csr_index) == CSR_LIMIT)) begin
         limit_in = csr_wdata[ITER_BITS-1:0];
      end
      pending_in = pending_ff + {15'd0, accept} - {15'd0, rsp_strobe};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff   <= LIMIT_RESET;
         pending_ff <= '0;
      end else begin
         limit_ff   <= limit_in;
         pending_ff <= pending_in;
      end
   end

   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result strobe right after reset");

   a_count_in_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_result.trapped |->
         rsp_result.escape_count >= 0 &&
         rsp_result.escape_count <= $signed({1'b0, limit_ff}))
      else $error("escape count outside zero to limit");

   a_trap_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_result.trapped |->
         rsp_result.escape_count <= 0 && rsp_result.escape_count >= TRAP_FLOOR)
      else $error("trap value out of range");

   a_no_orphan_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> pending_ff != '0)
      else $error("result without an outstanding request");

endmodule

bind escape_time_fractal_point_unit etfp_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_result (rsp_result),
   .csr_we     (csr_we),
   .csr_index  (csr_index),
   .csr_wdata  (csr_wdata)
);

[sim/escape_time_fractal_point_checker.sv]
// request/result checker of the escape-time point unit with its own iteration predictor
`timescale 1ns / 1ps

module escape_time_fractal_point_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  etfp_pkg::req_type               req_point,
   input  logic                            rsp_strobe,
   input  etfp_pkg::rsp_type               rsp_result,
   input  logic                            csr_we,
   input  logic [etfp_pkg::CSR_IW-1:0]     csr_index,
   input  logic [etfp_pkg::CSR_DW-1:0]     csr_wdata,
   output int                              mismatches,
   output int                              pending
);

   localparam int     FRAC        = etfp_pkg::FRAC_BITS;
   localparam int     CNT         = etfp_pkg::CNT_BITS;
   localparam longint Q_ONE       = longint'(1) <<< FRAC;
   localparam longint Q_FOUR      = 4 * Q_ONE;
   localparam longint Q_0P4       = (4 * Q_ONE + 5) / 10;
   localparam longint Q_0P6       = (6 * Q_ONE + 5) / 10;
   localparam longint Q_0P2       = (2 * Q_ONE + 5) / 10;
   localparam longint Q_1P2       = (12 * Q_ONE + 5) / 10;
   localparam longint Q_1P5       = (15 * Q_ONE + 5) / 10;
   localparam longint Q_0P7       = (7 * Q_ONE + 5) / 10;
   localparam longint Q_1P1       = (11 * Q_ONE + 5) / 10;
   localparam longint Q_0P05      = (5 * Q_ONE + 50) / 100;
   localparam longint Z_TOP       = (longint'(1) <<< (FRAC + 3)) - 1;
   localparam longint Z_BOTTOM    = -Z_TOP - 1;
   localparam longint PRODUCT_CAP = longint'(1) <<< 62;

   logic [etfp_pkg::ITER_BITS-1:0] cfg_limit;
   logic [etfp_pkg::MODE_BITS-1:0] cfg_mode;
   longint                         cfg_c_re;
   longint                         cfg_c_im;

   // escape counts still owed by the block, oldest first
   etfp_pkg::rsp_type awaited_counts[$];

   function automatic longint clamp_z(input longint v);
      if (v > Z_TOP) begin
         return Z_TOP;
      end else if (v < Z_BOTTOM) begin
         return Z_BOTTOM;
      end
      return v;
   endfunction

   // exact product, floored to the fraction width, magnitude capped
   function automatic longint mul_q(input longint a, input longint b);
      logic signed [127:0] wa;
      logic signed [127:0] wb;
      logic signed [127:0] prod;
      logic [127:0]        mag;
      logic                neg;
      logic                rem;
      longint              q;
      wa   = a;
      wb   = b;
      prod = wa * wb;
      neg  = prod[127];
      mag  = neg ? -prod : prod;
      rem  = |mag[FRAC-1:0];
      mag  = mag >> FRAC;
      if (mag > 128'(PRODUCT_CAP)) begin
         q = PRODUCT_CAP;
      end else begin
         q = longint'(mag[63:0]) + ((neg && rem) ? 1 : 0);
      end
      return neg ? -q : q;
   endfunction

   function automatic etfp_pkg::rsp_type escape_time_of(input etfp_pkg::req_type pt);
      etfp_pkg::rsp_type res;
      longint            zr;
      longint            zi;
      longint            cr;
      longint            ci;
      longint            nr;
      longint            ni;
      longint            x2;
      longint            y2;
      longint            trap_dist;
      longint            scaled;
      logic              esc;
      int                updates;
      if (cfg_mode[etfp_pkg::MODE_JULIA]) begin
         zr = clamp_z(longint'($signed(pt.point_re)));
         zi = clamp_z(longint'($signed(pt.point_im)));
         cr = cfg_c_re;
         ci = cfg_c_im;
      end else begin
         zr = 0;
         zi = 0;
         cr = longint'($signed(pt.point_re));
         ci = longint'($signed(pt.point_im));
      end
      res.trapped = 1'b0;
      updates = 0;
      for (int n = 0; n < int'(cfg_limit); n++) begin
         nr  = clamp_z(mul_q(zr, zr) - mul_q(zi, zi) + cr);
         ni  = clamp_z(mul_q(zr * 2, zi) + ci);
         // escape is judged before the burning-ship fold
         esc = (mul_q(nr, nr) + mul_q(ni, ni)) > Q_FOUR;
         if (cfg_mode[etfp_pkg::MODE_SHIP]) begin
            if (nr < 0) nr = clamp_z(-nr);
            if (ni < 0) ni = clamp_z(-ni);
         end
         zr = nr;
         zi = ni;
         updates++;
         if (cfg_mode[etfp_pkg::MODE_TRAP]) begin
            x2        = mul_q(Q_0P4, zr - Q_ONE) + (zi + Q_0P6) + Q_0P6;
            y2        = -mul_q(Q_0P2, zi + Q_1P2) + mul_q(Q_1P5, zr - Q_0P7) + Q_1P1;
            trap_dist = mul_q(x2, x2) + mul_q(y2, y2);
            if (trap_dist < 0) trap_dist = -trap_dist;
            // trap beats escape on the same update
            if (trap_dist < Q_0P05) begin
               scaled = (trap_dist * longint'(cfg_limit) * 100) / (15 * Q_ONE);
               res.escape_count = CNT'(-scaled);
               res.trapped      = 1'b1;
               return res;
            end
         end
         if (esc) break;
      end
      res.escape_count = CNT'(updates);
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatches < 100) $display("mismatch @%0t: %s", $time, what);
      mismatches++;
   endtask

   always @(posedge clock) begin
      etfp_pkg::rsp_type want;
      if (reset) begin
         cfg_limit = etfp_pkg::LIMIT_RESET;
         cfg_mode  = '0;
         cfg_c_re  = 0;
         cfg_c_im  = 0;
         awaited_counts.delete();
      end else begin
         if (rsp_strobe) begin
            if (awaited_counts.size() == 0) begin
               report_mismatch($sformatf("result count %0d trapped %0b with no request open",
                                         rsp_result.escape_count, rsp_result.trapped));
            end else begin
               want = awaited_counts.pop_front();
               if (rsp_result.escape_count !== want.escape_count)
                  report_mismatch($sformatf("escape_count %0d, predicted %0d",
                                            rsp_result.escape_count, want.escape_count));
               if (rsp_result.trapped !== want.trapped)
                  report_mismatch($sformatf("trapped %0b, predicted %0b",
                                            rsp_result.trapped, want.trapped));
            end
         end
         if (start && !busy) awaited_counts.push_back(escape_time_of(req_point));
         if (csr_we) begin
            case (csr_index)
               etfp_pkg::CSR_LIMIT: begin
                  cfg_limit = csr_wdata[etfp_pkg::ITER_BITS-1:0];
               end
               etfp_pkg::CSR_MODE: begin
                  cfg_mode = csr_wdata[etfp_pkg::MODE_BITS-1:0];
               end
               etfp_pkg::CSR_JULIA_RE: begin
                  cfg_c_re = longint'($signed(csr_wdata));
               end
               etfp_pkg::CSR_JULIA_IM: begin
                  cfg_c_im = longint'($signed(csr_wdata));
               end
               default: ;
            endcase
         end
      end
      pending = awaited_counts.size();
   end

endmodule

[sim/escape_time_fractal_point_unit_tb.sv]
// top testbench of the escape-time point unit: clock, reset, point and register stimulus, verdict
`timescale 1ns / 1ps

module escape_time_fractal_point_unit_tb;

   localparam int Q_ONE   = 32'h1000_0000;
   localparam int P_MAX   = 32'h7fff_ffff;
   localparam int P_MIN   = 32'h8000_0000;
   // point whose first update sits on the trap center
   localparam int TRAP_RE = 5100274;
   localparam int TRAP_IM = -216788474;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   etfp_pkg::req_type req_point;
   logic rsp_strobe;
   etfp_pkg::rsp_type rsp_result;
   logic csr_we;
   logic [etfp_pkg::CSR_IW-1:0] csr_index;
   logic [etfp_pkg::CSR_DW-1:0] csr_wdata;

   int mismatches;
   int pending;
   int points_sent;
   logic no_gaps;

   always #5 clock = ~clock;

   escape_time_fractal_point_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_point  (req_point),
      .rsp_strobe (rsp_strobe),
      .rsp_result (rsp_result),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   escape_time_fractal_point_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_point  (req_point),
      .rsp_strobe (rsp_strobe),
      .rsp_result (rsp_result),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   function automatic int idle_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic etfp_pkg::req_type random_point();
      etfp_pkg::req_type pt;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         pt.point_re = $urandom_range(0, 32'h4000_0000) - 32'h2800_0000;
         pt.point_im = $urandom_range(0, 32'h3000_0000) - 32'h1800_0000;
      end else if (pick < 75) begin
         pt.point_re = TRAP_RE + $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
         pt.point_im = TRAP_IM + $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
      end else if (pick < 85) begin
         pt.point_re = $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
         pt.point_im = $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
      end else begin
         pt.point_re = $urandom();
         pt.point_im = $urandom();
      end
      return pt;
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic issue_point(input int re, input int im);
      int gap;
      start     <= 1'b1;
      req_point <= '{point_re: re, point_im: im};
      while (busy) @(negedge clock);
      @(negedge clock);
      points_sent++;
      gap = idle_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      // engine may still be flushing updates it ran ahead
      repeat (12) @(negedge clock);
   endtask

   task automatic configure(input int limit, input int mode, input int c_re, input int c_im);
      drain();
      csr_we    <= 1'b1;
      csr_index <= etfp_pkg::CSR_LIMIT;
      csr_wdata <= limit;
      @(negedge clock);
      csr_index <= etfp_pkg::CSR_MODE;
      csr_wdata <= mode;
      @(negedge clock);
      csr_index <= etfp_pkg::CSR_JULIA_RE;
      csr_wdata <= c_re;
      @(negedge clock);
      csr_index <= etfp_pkg::CSR_JULIA_IM;
      csr_wdata <= c_im;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_directed();
      int julia_trap_ship;
      julia_trap_ship = (1 << etfp_pkg::MODE_JULIA) | (1 << etfp_pkg::MODE_TRAP)
                        | (1 << etfp_pkg::MODE_SHIP);
      // register defaults after reset
      issue_point(0, 0);
      issue_point(-Q_ONE, 0);
      issue_point(2 * Q_ONE, 2 * Q_ONE);
      issue_point(P_MAX, P_MAX);
      issue_point(P_MIN, P_MIN);
      issue_point(P_MAX, P_MIN);
      issue_point(P_MIN, P_MAX);
      issue_point(-2 * Q_ONE, 0);
      issue_point(Q_ONE, 0);
      issue_point(TRAP_RE, TRAP_IM);
      // limit of zero
      configure(0, 0, 0, 0);
      issue_point(0, 0);
      issue_point(P_MIN, P_MAX);
      // orbit trap on the first update, and a far escape
      configure(50, 1 << etfp_pkg::MODE_TRAP, 0, 0);
      issue_point(TRAP_RE, TRAP_IM);
      issue_point(2 * Q_ONE, 2 * Q_ONE);
      // trap value of zero
      configure(1, 1 << etfp_pkg::MODE_TRAP, 0, 0);
      issue_point(TRAP_RE, TRAP_IM);
      // saturation, fold of the most negative value
      configure(4095, julia_trap_ship, P_MIN, P_MIN);
      issue_point(P_MIN, P_MIN);
      issue_point(0, 0);
      configure(50, 1 << etfp_pkg::MODE_JULIA, -214748365, 41875931);
      issue_point(0, 0);
      issue_point(80530637, -53687091);
      configure(20, 1 << etfp_pkg::MODE_SHIP, 0, 0);
      issue_point(-469762048, -8053064);
      issue_point(P_MIN, 0);
      configure(4095, 0, P_MAX, P_MAX);
      issue_point(0, 0);
      issue_point(-Q_ONE, 0);
   endtask

   task automatic run_random();
      int unsigned pick;
      int limit;
      int count;
      int c_re;
      int c_im;
      etfp_pkg::req_type pt;
      while (points_sent < 1350) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            limit = 0;
            count = 8;
         end else if (pick < 14) begin
            limit = 1;
            count = 30;
         end else if (pick < 20) begin
            limit = 4095;
            count = 3;
         end else if (pick < 26) begin
            limit = $urandom_range(65, 4095);
            count = 3;
         end else begin
            limit = $urandom_range(2, 64);
            count = $urandom_range(20, 60);
         end
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            c_re = $urandom_range(0, 32'h1800_0000) - 32'h1000_0000;
            c_im = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
         end else if (pick < 70) begin
            c_re = TRAP_RE + $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
            c_im = TRAP_IM + $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
         end else begin
            c_re = $urandom();
            c_im = $urandom();
         end
         configure(limit, $urandom_range(0, 7), c_re, c_im);
         no_gaps = ($urandom_range(0, 3) == 0);
         repeat (count) begin
            pt = random_point();
            issue_point(pt.point_re, pt.point_im);
         end
         no_gaps = 1'b0;
      end
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_point   = '0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      points_sent = 0;
      no_gaps     = 1'b0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      drain();
      if (mismatches == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[sim.f]
design/etfp_pkg.sv
design/etfp_front.sv
design/etfp_fifo.sv
design/etfp_core.sv
design/escape_time_fractal_point_unit.sv
design/etfp_checker.sv
sim/escape_time_fractal_point_checker.sv
sim/escape_time_fractal_point_unit_tb.sv
